@@ rtl/ocrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocrs_pkg
// Shared types for the oscillator count ranking sorter.
// ----------------------------------------------------------------------------
package ocrs_pkg;

  localparam int RING_W  = 6;
  localparam int COUNT_W = 32;

  // one stored ring entry: index and 64-bit key high:low
  typedef struct packed {
    logic [RING_W-1:0]  ring;
    logic [COUNT_W-1:0] hi;
    logic [COUNT_W-1:0] lo;
  } entry_t;

  // sequencer to output stage control
  typedef struct packed {
    logic load;
    logic last;
  } emit_ctl_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEL_START,
    ST_SEL_FIRST,
    ST_SCAN,
    ST_SWAP_P,
    ST_SWAP_BEST,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage
`default_nettype wire

@@ rtl/ocrs_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocrs_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ocrs_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire ocrs_pkg::entry_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output ocrs_pkg::entry_t      rd_data
);
  import ocrs_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/ocrs_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocrs_seq
// Sequencer: loads a batch, runs the selection sort through the entry
// memory with one comparator, then reads the ranked entries out.
// ----------------------------------------------------------------------------
module ocrs_seq #(
  parameter int NUM_RINGS = 8,
  parameter int AW        = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ocrs_pkg::COUNT_W-1:0]      in_count_high,
  input  wire logic [ocrs_pkg::COUNT_W-1:0]      in_count_low,
  input  wire logic                              out_free,
  output ocrs_pkg::emit_ctl_t                    emit,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output ocrs_pkg::entry_t                       mem_wdata,
  output logic                                   mem_re,
  output logic [AW-1:0]                          mem_raddr,
  input  wire ocrs_pkg::entry_t                  mem_rdata
);
  import ocrs_pkg::*;

  localparam logic [AW-1:0] LAST   = AW'(NUM_RINGS - 1);
  localparam logic [AW-1:0] LAST_P = AW'(NUM_RINGS - 2);

  state_t         state_r, state_nxt;
  logic [AW-1:0]  fill_r, fill_nxt;
  logic [AW-1:0]  p_r, p_nxt;
  logic [AW-1:0]  q_r, q_nxt;
  logic [AW-1:0]  e_r, e_nxt;
  logic [AW-1:0]  best_addr_r, best_addr_nxt;
  entry_t         best_r, best_nxt;
  entry_t         pent_r, pent_nxt;
  logic           in_xfer;
  logic           greater;

  assign in_xfer = in_valid && (state_r == ST_LOAD);
  assign greater = {mem_rdata.hi, mem_rdata.lo} > {best_r.hi, best_r.lo};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && fill_r == LAST) state_nxt = ST_SEL_START;
      end
      ST_SEL_START: state_nxt = ST_SEL_FIRST;
      ST_SEL_FIRST: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (q_r == LAST) state_nxt = ST_SWAP_P;
      end
      ST_SWAP_P: state_nxt = ST_SWAP_BEST;
      ST_SWAP_BEST: begin
        state_nxt = (p_r == LAST_P) ? ST_EMIT_RD : ST_SEL_START;
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free) state_nxt = (e_r == LAST) ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs: handshake, memory ports, emit control
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = fill_r;
    mem_wdata = '{ring: RING_W'(fill_r), hi: in_count_high, lo: in_count_low};
    mem_re    = 1'b0;
    mem_raddr = p_r;
    emit      = '{load: 1'b0, last: 1'b0};
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        mem_we   = in_valid;
      end
      ST_SEL_START: begin
        mem_re = 1'b1;
      end
      ST_SEL_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = p_r + 1'b1;
      end
      ST_SCAN: begin
        mem_re    = (q_r != LAST);
        mem_raddr = q_r + 1'b1;
      end
      ST_SWAP_P: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        mem_wdata = best_r;
      end
      ST_SWAP_BEST: begin
        mem_we    = 1'b1;
        mem_waddr = best_addr_r;
        mem_wdata = pent_r;
      end
      ST_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = e_r;
      end
      ST_EMIT_LD: begin
        emit = '{load: out_free, last: (e_r == LAST)};
      end
      default: ;
    endcase
  end

  // counters and the running maximum
  always_comb begin
    fill_nxt      = fill_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    e_nxt         = e_r;
    best_nxt      = best_r;
    best_addr_nxt = best_addr_r;
    pent_nxt      = pent_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (fill_r == LAST) begin
            fill_nxt = '0;
            p_nxt    = '0;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ST_SEL_FIRST: begin
        q_nxt = p_r + 1'b1;
      end
      ST_SCAN: begin
        if (q_r != LAST) q_nxt = q_r + 1'b1;
        if (greater) begin
          best_nxt      = mem_rdata;
          best_addr_nxt = q_r;
        end
      end
      ST_SWAP_BEST: begin
        p_nxt = p_r + 1'b1;
        e_nxt = '0;
      end
      ST_EMIT_LD: begin
        if (out_free) e_nxt = (e_r == LAST) ? '0 : e_r + 1'b1;
      end
      default: ;
    endcase
    // entry p arrives in the cycle after its read
    if (state_r == ST_SEL_FIRST) begin
      best_nxt      = mem_rdata;
      best_addr_nxt = p_r;
      pent_nxt      = mem_rdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      p_r     <= '0;
      q_r     <= '0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      e_r     <= e_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    best_addr_r <= best_addr_nxt;
    pent_r      <= pent_nxt;
  end

  // checks
  a_scan_after_p: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> q_r > p_r)
    else $error("scan position not above sort position");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWAP_P |-> (best_addr_r >= p_r && best_addr_r <= LAST))
    else $error("selected entry outside the unsorted range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> out_free)
    else $error("emit into an occupied output register");

  a_last_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load && emit.last |=> state_r == ST_LOAD && fill_r == '0)
    else $error("batch did not end after the last rank");

endmodule
`default_nettype wire

@@ rtl/oscillator_count_ranking_sort.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oscillator_count_ranking_sort
// Ranks a batch of ring-oscillator counts from fastest to slowest.
// ----------------------------------------------------------------------------
// The block takes NUM_RINGS count items, one per cycle while the input does
// not stall, each one ring's 64-bit count high:low; the arrival position is
// the ring index. After the last item of a batch the input stalls while a
// selection sort runs through an entry memory with one write port and one
// read port and one 64-bit comparator: each position takes one memory read
// per scanned entry plus two write-backs for the swap. The ranked entries
// then leave one at a time, each read from memory and then loaded into the
// output register once it is free, the last one flagged with out_last_rank.
// The next batch may load while the last result still waits in the output
// register.
// ----------------------------------------------------------------------------
module oscillator_count_ranking_sort #(
  parameter int NUM_RINGS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ocrs_pkg::COUNT_W-1:0]     in_count_high,
  input  wire logic [ocrs_pkg::COUNT_W-1:0]     in_count_low,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ocrs_pkg::RING_W-1:0]           out_ring_index,
  output logic [ocrs_pkg::COUNT_W-1:0]          out_ranked_high,
  output logic [ocrs_pkg::COUNT_W-1:0]          out_ranked_low,
  output logic                                  out_last_rank
);
  import ocrs_pkg::*;

  localparam int AW = $clog2(NUM_RINGS);

  emit_ctl_t     emit;
  logic          out_free;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  logic          out_valid_r;
  entry_t        out_entry_r;
  logic          out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  ocrs_seq #(
    .NUM_RINGS (NUM_RINGS),
    .AW        (AW)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_count_high (in_count_high),
    .in_count_low  (in_count_low),
    .out_free      (out_free),
    .emit          (emit),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  ocrs_store #(
    .DEPTH (NUM_RINGS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_entry_r <= mem_rdata;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ring_index  = out_entry_r.ring;
  assign out_ranked_high = out_entry_r.hi;
  assign out_ranked_low  = out_entry_r.lo;
  assign out_last_rank   = out_last_r;

endmodule
`default_nettype wire

@@ sim/ocrs_rank_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocrs_rank_checker
// Watches both channels of the ranking sorter, predicts the ranked order of
// each completed batch with a descending selection sort and compares every
// result transfer field by field against the oldest predicted rank.
// ----------------------------------------------------------------------------
module ocrs_rank_checker #(
  parameter int NUM_RINGS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [ocrs_pkg::COUNT_W-1:0] in_count_high,
  input  wire logic [ocrs_pkg::COUNT_W-1:0] in_count_low,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [ocrs_pkg::RING_W-1:0]  out_ring_index,
  input  wire logic [ocrs_pkg::COUNT_W-1:0] out_ranked_high,
  input  wire logic [ocrs_pkg::COUNT_W-1:0] out_ranked_low,
  input  wire logic                         out_last_rank,
  output int                                fault_count,
  output int                                ranks_pending
);
  import ocrs_pkg::*;

  localparam int REPORT_MAX = 10;

  // one predicted rank: the ring entry and its end-of-batch flag
  typedef struct packed {
    entry_t ent;
    logic   last;
  } rank_t;

  entry_t      ring_counts [NUM_RINGS];
  int unsigned rings_loaded = 0;
  rank_t       rank_q [$];
  int          faults = 0;

  // descending selection sort; the first strictly greatest key wins a scan
  task automatic rank_batch();
    entry_t work [NUM_RINGS];
    entry_t swap_tmp;
    int     best;
    rank_t  r;
    work = ring_counts;
    for (int p = 0; p < NUM_RINGS; p++) begin
      best = p;
      for (int q = p + 1; q < NUM_RINGS; q++) begin
        if ({work[q].hi, work[q].lo} > {work[best].hi, work[best].lo}) begin
          best = q;
        end
      end
      if (best != p) begin
        swap_tmp   = work[p];
        work[p]    = work[best];
        work[best] = swap_tmp;
      end
    end
    for (int k = 0; k < NUM_RINGS; k++) begin
      r.ent  = work[k];
      r.last = (k == NUM_RINGS - 1);
      rank_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    rank_t want;
    if (!rst_n) begin
      rings_loaded = 0;
      rank_q.delete();
    end else begin
      // input transfer: store the ring under its arrival position
      if (in_valid && !in_stall) begin
        ring_counts[rings_loaded] = '{ring: RING_W'(rings_loaded),
                                      hi: in_count_high, lo: in_count_low};
        rings_loaded++;
        if (rings_loaded == NUM_RINGS) begin
          rings_loaded = 0;
          rank_batch();
        end
      end
      // result transfer: compare with the oldest predicted rank
      if (out_valid && !out_stall) begin
        if (rank_q.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX) begin
            $display("unexpected rank: ring %0d %h:%h last %0b",
                     out_ring_index, out_ranked_high, out_ranked_low, out_last_rank);
          end
        end else begin
          want = rank_q.pop_front();
          if (out_ring_index !== want.ent.ring || out_ranked_high !== want.ent.hi ||
              out_ranked_low !== want.ent.lo || out_last_rank !== want.last) begin
            faults++;
            if (faults <= REPORT_MAX) begin
              $display({"rank mismatch: expected ring %0d %h:%h last %0b, ",
                        "got ring %0d %h:%h last %0b"},
                       want.ent.ring, want.ent.hi, want.ent.lo, want.last,
                       out_ring_index, out_ranked_high, out_ranked_low, out_last_rank);
            end
          end
        end
      end
    end
    fault_count   <= faults;
    ranks_pending <= rank_q.size();
  end

endmodule

@@ sim/oscillator_count_ranking_sort_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oscillator_count_ranking_sort_tb
// Feeds batches of ring counts into the ranking sorter: a few hand-picked
// batches with extreme and tied keys, then random batches, some built to
// produce ties and monotone runs, with random idling on both channels and long
// output hold-offs that back the block up into its input.
// ----------------------------------------------------------------------------
module oscillator_count_ranking_sort_tb;
  import ocrs_pkg::*;

  localparam int NUM_RINGS      = 8;
  localparam int RANDOM_BATCHES = 48;
  localparam int HOLD_CYCLES    = 500;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LIMIT_CYCLES   = 400000;

  // how the keys of one random batch are drawn
  typedef enum logic [1:0] {
    MIX_FREE,
    MIX_SHARED_HIGH,
    MIX_TIED,
    MIX_RUN
  } batch_mix_t;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic [COUNT_W-1:0]   in_count_high = '0;
  logic [COUNT_W-1:0]   in_count_low  = '0;
  logic                 out_stall     = 1'b0;
  wire logic            in_stall;
  wire logic            out_valid;
  wire logic [RING_W-1:0]  out_ring_index;
  wire logic [COUNT_W-1:0] out_ranked_high;
  wire logic [COUNT_W-1:0] out_ranked_low;
  wire logic            out_last_rank;
  int                   fault_count;
  int                   ranks_pending;

  int   rings_sent     = 0;
  logic calm           = 1'b0;
  int   calm_left      = 0;
  logic receiver_hold  = 1'b0;
  int   stall_left     = 0;

  logic [63:0] directed_keys [0:23] = '{
    // extremes of both words
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
    64'h0000_0001_0000_0000, 64'h0000_0000_0000_0001,
    64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF,
    // repeated full keys, tie order set by the swaps
    64'h0000_0005_A5A5_A5A5, 64'h0000_0009_A5A5_A5A5,
    64'h0000_0005_A5A5_A5A5, 64'h0000_0009_A5A5_A5A5,
    64'h0000_0002_A5A5_A5A5, 64'h0000_0009_A5A5_A5A5,
    64'h0000_0005_A5A5_A5A5, 64'h0000_0002_A5A5_A5A5,
    // equal high word, low word decides
    64'h1357_9BDF_0000_0003, 64'h1357_9BDF_0000_0007,
    64'h1357_9BDF_0000_0003, 64'h1357_9BDF_0000_0000,
    64'h1357_9BDF_FFFF_FFFF, 64'h1357_9BDF_0000_0007,
    64'h1357_9BDF_0000_0001, 64'h1357_9BDF_FFFF_FFFF
  };

  oscillator_count_ranking_sort #(.NUM_RINGS(NUM_RINGS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_count_high   (in_count_high),
    .in_count_low    (in_count_low),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ring_index  (out_ring_index),
    .out_ranked_high (out_ranked_high),
    .out_ranked_low  (out_ranked_low),
    .out_last_rank   (out_last_rank)
  );

  ocrs_rank_checker #(.NUM_RINGS(NUM_RINGS)) rank_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_count_high   (in_count_high),
    .in_count_low    (in_count_low),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ring_index  (out_ring_index),
    .out_ranked_high (out_ranked_high),
    .out_ranked_low  (out_ranked_low),
    .out_last_rank   (out_last_rank),
    .fault_count     (fault_count),
    .ranks_pending   (ranks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // idle stretch length: mostly short, now and then long
  function automatic int burst_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // alternate between idling phases and calm phases with no idling
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(100, 400);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // receiver stall: random bursts plus the long hold-off
  always @(posedge clk) begin : receiver
    logic burst;
    if (stall_left != 0) begin
      burst = 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      burst = 1'b1;
      stall_left <= burst_length() - 1;
    end else begin
      burst = 1'b0;
    end
    out_stall <= receiver_hold | burst;
  end

  // long hold-off while the sender keeps offering, so the block backs up
  initial begin : pressure
    int marks [2] = '{40, 260};
    foreach (marks[m]) begin
      wait (rings_sent >= marks[m]);
      @(posedge clk);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      receiver_hold <= 1'b0;
    end
  end

  // one ring count transfer, after an optional idle gap
  task automatic send_count(input logic [COUNT_W-1:0] hi, input logic [COUNT_W-1:0] lo);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : burst_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_count_high <= hi;
    in_count_low  <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rings_sent++;
  endtask

  initial begin : stimulus
    batch_mix_t  mix;
    logic [63:0] pool [3];
    logic [63:0] base;
    logic [63:0] key;
    logic        rising;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-picked batches
    foreach (directed_keys[i]) begin
      send_count(directed_keys[i][63:32], directed_keys[i][31:0]);
    end

    // random batches
    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      mix    = batch_mix_t'($urandom_range(0, 3));
      rising = 1'($urandom_range(0, 1));
      base   = {$urandom, $urandom};
      for (int j = 0; j < 3; j++) begin
        pool[j] = {$urandom, $urandom};
      end
      for (int i = 0; i < NUM_RINGS; i++) begin
        case (mix)
          MIX_FREE: begin
            key = {$urandom, $urandom};
          end
          MIX_SHARED_HIGH: begin
            key[63:32] = pool[$urandom_range(0, 1)][63:32];
            key[31:0]  = ($urandom_range(0, 2) == 0) ? pool[2][31:0] : $urandom;
          end
          MIX_TIED: begin
            key = pool[$urandom_range(0, 2)];
          end
          default: begin
            key = rising ? base + i : base - i;
          end
        endcase
        send_count(key[63:32], key[31:0]);
      end
    end
    in_valid <= 1'b0;

    // drain the remaining ranks
    @(posedge clk);
    while (ranks_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && ranks_pending == 0) begin
      $display("oscillator_count_ranking_sort verification clean");
    end else begin
      $display("oscillator_count_ranking_sort verification failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("oscillator_count_ranking_sort verification failed");
    $finish;
  end

endmodule

@@ oscillator_count_ranking_sort.f @@
rtl/ocrs_pkg.sv
rtl/ocrs_store.sv
rtl/ocrs_seq.sv
rtl/oscillator_count_ranking_sort.sv
sim/ocrs_rank_checker.sv
sim/oscillator_count_ranking_sort_tb.sv
